FILE: hw/rtl/tsp_pkg.sv
// Shared types and constants of the trapezoid speed profile block.
// Used by tsp_front, tsp_sqrt_cell and trapezoid_speed_profile; depends on nothing.
package tsp_pkg;

  localparam int CELL_COUNT_WIDTH = 16;
  localparam int SPEED_W          = 16;
  localparam int ACCEL_W          = 16;
  localparam int CELL_SIZE_W      = 17;
  localparam int DIST_W           = CELL_COUNT_WIDTH + CELL_SIZE_W;
  localparam int PROD_W           = DIST_W + ACCEL_W;
  localparam int NUM_W            = 42;
  localparam int REM_W            = 41;
  localparam int ROOT_W           = 34;
  localparam int TRIAL_W          = ROOT_W + 9;
  localparam int SQRT_STEPS       = SPEED_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = CELL_SIZE_W;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ACCEL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE = 2'd2;

  localparam logic [SPEED_W-1:0]     RST_MAX_SPEED = 16'd500;
  localparam logic [ACCEL_W-1:0]     RST_MAX_ACCEL = 16'd500;
  localparam logic [CELL_SIZE_W-1:0] RST_CELL_SIZE = 17'd50000;

  localparam logic [SPEED_W-1:0] FLOOR_SPEED = 16'd120;
  localparam logic [SPEED_W-1:0] START_SPEED = 16'd150;
  localparam logic [SPEED_W-1:0] SAT_SPEED   = 16'hFFFF;
  localparam logic [63:0] START_ZONE_UM = 64'd200000;
  // Past-end distances at or above 2000 * 65536 um saturate the speed.
  localparam logic [63:0] PAST_SAT_UM   = 64'd131072000;
  // floor(2^22 / 125): reciprocal for the divide by 125 after a shift by 4.
  localparam logic [15:0] RECIP_125     = 16'd33554;
  // Radicands at or above 500 * 2^32 give a root beyond the output range.
  localparam logic [63:0] SAT_RADICAND  = 64'd2147483648000;
  localparam logic [ROOT_W-1:0] FIRST_BIT = ROOT_W'(64'd1 << (2 * (SQRT_STEPS - 1)));

  typedef enum logic [1:0] {
    KIND_FIXED,
    KIND_RAMP,
    KIND_PAST
  } tsp_kind_t;

  typedef struct packed {
    logic [SPEED_W-1:0]     max_speed;
    logic [ACCEL_W-1:0]     max_accel;
    logic [CELL_SIZE_W-1:0] cell_size;
  } tsp_cfg_t;

  typedef struct packed {
    logic [REM_W-1:0]   rem;
    logic [ROOT_W-1:0]  root;
    logic [ROOT_W-1:0]  bitw;
    logic               fixed;
    logic [SPEED_W-1:0] fixval;
  } tsp_cell_t;

endpackage

FILE: hw/rtl/tsp_front.sv
// Front pipeline: scales cell counts to micrometres, picks the profile zone
// and prepares the radicand for the square root chain. Depends on tsp_pkg.
module tsp_front (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [tsp_pkg::CELL_COUNT_WIDTH-1:0]   in_travelled_cells,
  input  logic [tsp_pkg::CELL_COUNT_WIDTH-1:0]   in_segment_cells,
  input  tsp_pkg::tsp_cfg_t                      cfg,
  output logic                                   dn_valid,
  output tsp_pkg::tsp_cell_t                     dn_data,
  input  logic                                   dn_ready
);

  localparam int DW = tsp_pkg::DIST_W;
  localparam int PW = tsp_pkg::PROD_W;
  localparam int NW = tsp_pkg::NUM_W;

  // Stage A: distances and vmax squared.
  logic                       a_v_r;
  logic [DW-1:0]              a_s2_r, a_len_r;
  logic [31:0]                a_vv_r;
  logic [tsp_pkg::ACCEL_W-1:0] a_acc_r;
  logic [tsp_pkg::SPEED_W-1:0] a_vmax_r;

  // Stage B: products and zone flags.
  logic                       b_v_r;
  logic [NW-1:0]              b_num_r;
  logic [PW-1:0]              b_as_r, b_lena_r;
  logic                       b_past_r, b_start_r, b_half_r, b_accnz_r;
  logic [DW-1:0]              b_diff_r;
  logic [tsp_pkg::SPEED_W-1:0] b_vmax_r;

  // Stage C: zone decision.
  logic                       c_v_r;
  tsp_pkg::tsp_kind_t         c_kind_r;
  logic [tsp_pkg::SPEED_W-1:0] c_fixval_r;
  logic [PW-1:0]              c_rad_r;
  logic [22:0]                c_px_r;
  logic [16:0]                c_q0_r;
  logic                       c_psat_r;

  // Stage D: cell chain entry.
  logic                       d_v_r;
  tsp_pkg::tsp_cell_t         d_data_r;

  logic rdy_a, rdy_b, rdy_c, rdy_d;

  assign rdy_d    = !d_v_r || dn_ready;
  assign rdy_c    = !c_v_r || rdy_d;
  assign rdy_b    = !b_v_r || rdy_c;
  assign rdy_a    = !a_v_r || rdy_b;
  assign in_stall = !rdy_a;
  assign dn_valid = d_v_r;
  assign dn_data  = d_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
    end else begin
      if (rdy_a) a_v_r <= in_valid;
      if (rdy_b) b_v_r <= a_v_r;
      if (rdy_c) c_v_r <= b_v_r;
      if (rdy_d) d_v_r <= c_v_r;
    end
  end

  // Stage A payload.
  always_ff @(posedge clk) begin
    if (rdy_a && in_valid) begin
      a_s2_r   <= DW'(in_travelled_cells) * DW'(cfg.cell_size);
      a_len_r  <= DW'(in_segment_cells) * DW'(cfg.cell_size);
      a_vv_r   <= 32'(cfg.max_speed) * 32'(cfg.max_speed);
      a_acc_r  <= cfg.max_accel;
      a_vmax_r <= cfg.max_speed;
    end
  end

  // Stage B payload. 1000 * vv is built from shifts.
  logic [NW-1:0] num_nxt;
  assign num_nxt = (NW'(a_vv_r) << 10) - (NW'(a_vv_r) << 4) - (NW'(a_vv_r) << 3);

  always_ff @(posedge clk) begin
    if (rdy_b && a_v_r) begin
      b_num_r   <= num_nxt;
      b_as_r    <= PW'(a_s2_r) * PW'(a_acc_r);
      b_lena_r  <= PW'(a_len_r) * PW'(a_acc_r);
      b_past_r  <= a_s2_r > a_len_r;
      b_start_r <= 64'(a_s2_r) < tsp_pkg::START_ZONE_UM;
      b_half_r  <= {a_s2_r, 1'b0} <= {1'b0, a_len_r};
      b_accnz_r <= a_acc_r != '0;
      b_diff_r  <= a_s2_r - a_len_r;
      b_vmax_r  <= a_vmax_r;
    end
  end

  // Stage C: the ramp tests against s1 are done as a*x compared with
  // 1000*vmax^2/2, which avoids any division.
  logic [PW-1:0]              ad;
  logic [PW:0]                as2, ad2, num_x;
  logic                       is_long;
  logic [63:0]                diff64;
  tsp_pkg::tsp_kind_t         kind_nxt;
  logic [tsp_pkg::SPEED_W-1:0] fixval_nxt;
  logic [PW-1:0]              rad_nxt;

  always_comb begin
    ad      = b_lena_r - b_as_r;
    as2     = {b_as_r, 1'b0};
    ad2     = {ad, 1'b0};
    num_x   = (PW + 1)'(b_num_r);
    is_long = b_accnz_r && ({1'b0, b_lena_r} >= num_x);
    diff64  = 64'(b_diff_r);
    kind_nxt   = tsp_pkg::KIND_RAMP;
    fixval_nxt = tsp_pkg::START_SPEED;
    rad_nxt    = b_as_r;
    if (b_past_r) begin
      kind_nxt = tsp_pkg::KIND_PAST;
    end else if (b_start_r) begin
      kind_nxt = tsp_pkg::KIND_FIXED;
    end else if (is_long) begin
      if (as2 < num_x) begin
        rad_nxt = b_as_r;
      end else if (ad2 >= num_x) begin
        kind_nxt   = tsp_pkg::KIND_FIXED;
        fixval_nxt = b_vmax_r;
      end else begin
        rad_nxt = ad;
      end
    end else begin
      rad_nxt = b_half_r ? b_as_r : ad;
    end
  end

  logic [38:0] q0_prod;
  assign q0_prod = 39'(diff64[26:4]) * 39'(tsp_pkg::RECIP_125);

  always_ff @(posedge clk) begin
    if (rdy_c && b_v_r) begin
      c_kind_r   <= kind_nxt;
      c_fixval_r <= fixval_nxt;
      c_rad_r    <= rad_nxt;
      c_px_r     <= diff64[26:4];
      c_q0_r     <= q0_prod[38:22];
      c_psat_r   <= diff64 >= tsp_pkg::PAST_SAT_UM;
    end
  end

  // Stage D: finish the divide by 2000 and check the radicand range.
  logic [24:0]        q_rem;
  logic [16:0]        q_fin;
  tsp_pkg::tsp_cell_t d_nxt;

  always_comb begin
    q_rem = {2'b00, c_px_r} - 25'(c_q0_r) * 25'(7'd125);
    q_fin = c_q0_r + ((q_rem >= 25'd125) ? 17'd1 : 17'd0);
    d_nxt.rem    = '0;
    d_nxt.root   = '0;
    d_nxt.bitw   = tsp_pkg::FIRST_BIT;
    d_nxt.fixed  = 1'b1;
    d_nxt.fixval = c_fixval_r;
    case (c_kind_r)
      tsp_pkg::KIND_FIXED: d_nxt.fixval = c_fixval_r;
      tsp_pkg::KIND_PAST: begin
        d_nxt.fixval = c_psat_r ? tsp_pkg::SAT_SPEED : q_fin[15:0];
      end
      tsp_pkg::KIND_RAMP: begin
        if (64'(c_rad_r) >= tsp_pkg::SAT_RADICAND) begin
          d_nxt.fixval = tsp_pkg::SAT_SPEED;
        end else begin
          d_nxt.fixed = 1'b0;
          d_nxt.rem   = c_rad_r[tsp_pkg::REM_W-1:0];
        end
      end
      default: d_nxt.fixval = c_fixval_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy_d && c_v_r) begin
      d_data_r <= d_nxt;
    end
  end

endmodule

FILE: hw/rtl/tsp_sqrt_cell.sv
// One digit cell of the square root chain: decides one root bit of
// floor(sqrt(rad / 500)) and hands the partial result on. Depends on tsp_pkg.
module tsp_sqrt_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  input  tsp_pkg::tsp_cell_t up_data,
  output logic               up_ready,
  output logic               dn_valid,
  output tsp_pkg::tsp_cell_t dn_data,
  input  logic               dn_ready
);

  logic               v_r;
  tsp_pkg::tsp_cell_t data_r;
  tsp_pkg::tsp_cell_t data_nxt;

  logic [tsp_pkg::ROOT_W-1:0]  sum;
  logic [tsp_pkg::TRIAL_W-1:0] trial;

  assign up_ready = !v_r || dn_ready;
  assign dn_valid = v_r;
  assign dn_data  = data_r;

  // The remainder is kept scaled by 500, so the trial term is 500 * (root + bit).
  always_comb begin
    sum   = up_data.root + up_data.bitw;
    trial = (tsp_pkg::TRIAL_W'(sum) << 9) - (tsp_pkg::TRIAL_W'(sum) << 3)
          - (tsp_pkg::TRIAL_W'(sum) << 2);
    data_nxt      = up_data;
    data_nxt.bitw = up_data.bitw >> 2;
    if (!up_data.fixed) begin
      if (tsp_pkg::TRIAL_W'(up_data.rem) >= trial) begin
        data_nxt.rem  = up_data.rem - trial[tsp_pkg::REM_W-1:0];
        data_nxt.root = (up_data.root >> 1) + up_data.bitw;
      end else begin
        data_nxt.root = up_data.root >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

FILE: hw/rtl/trapezoid_speed_profile.sv
// Top level of the trapezoid speed profile: configuration registers, front
// pipeline, a chain of square root cells and the output register.
// Depends on tsp_pkg, tsp_front and tsp_sqrt_cell.
//
//   channel  direction  handshake          payload
//   in       input      in_valid/in_stall   in_travelled_cells, in_segment_cells
//   out      output     out_valid/out_stall out_speed_mm_s
//   cfg      input      cfg_we              cfg_addr, cfg_wdata
//
// One item is accepted per cycle while in_stall is low. The item passes 21
// registers (four front stages, sixteen root cells, one output register) on its
// way to the output, where it is taken while out_stall is low.
// Every stage holds its item only while the stage after it is full and stalled,
// so empty stages keep taking items while a result waits at the output.
// Reset is synchronous and loads the default vmax, amax and cell size.
module trapezoid_speed_profile (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [tsp_pkg::CELL_COUNT_WIDTH-1:0] in_travelled_cells,
  input  logic [tsp_pkg::CELL_COUNT_WIDTH-1:0] in_segment_cells,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [tsp_pkg::SPEED_W-1:0]          out_speed_mm_s,
  input  logic                                 cfg_we,
  input  logic [tsp_pkg::CFG_IDX_W-1:0]        cfg_addr,
  input  logic [tsp_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  localparam int N = tsp_pkg::SQRT_STEPS;

  tsp_pkg::tsp_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_speed <= tsp_pkg::RST_MAX_SPEED;
      cfg_r.max_accel <= tsp_pkg::RST_MAX_ACCEL;
      cfg_r.cell_size <= tsp_pkg::RST_CELL_SIZE;
    end else if (cfg_we) begin
      case (cfg_addr)
        tsp_pkg::CFG_MAX_SPEED: cfg_r.max_speed <= cfg_wdata[tsp_pkg::SPEED_W-1:0];
        tsp_pkg::CFG_MAX_ACCEL: cfg_r.max_accel <= cfg_wdata[tsp_pkg::ACCEL_W-1:0];
        tsp_pkg::CFG_CELL_SIZE: cfg_r.cell_size <= cfg_wdata;
        default: cfg_r <= cfg_r;
      endcase
    end
  end

  logic               cv [N+1];
  tsp_pkg::tsp_cell_t cd [N+1];
  logic               cr [N+1];

  tsp_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_travelled_cells (in_travelled_cells),
    .in_segment_cells   (in_segment_cells),
    .cfg                (cfg_r),
    .dn_valid           (cv[0]),
    .dn_data            (cd[0]),
    .dn_ready           (cr[0])
  );

  for (genvar i = 0; i < N; i++) begin : g_cell
    tsp_sqrt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (cv[i]),
      .up_data  (cd[i]),
      .up_ready (cr[i]),
      .dn_valid (cv[i+1]),
      .dn_data  (cd[i+1]),
      .dn_ready (cr[i+1])
    );
  end

  logic                        out_valid_r;
  logic [tsp_pkg::SPEED_W-1:0] speed_r;
  logic [tsp_pkg::SPEED_W-1:0] speed_nxt;

  assign cr[N] = !out_valid_r || !out_stall;

  always_comb begin
    speed_nxt = cd[N].fixed ? cd[N].fixval : cd[N].root[tsp_pkg::SPEED_W-1:0];
    if (speed_nxt < tsp_pkg::FLOOR_SPEED) begin
      speed_nxt = tsp_pkg::FLOOR_SPEED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cr[N]) begin
      out_valid_r <= cv[N];
    end
  end

  always_ff @(posedge clk) begin
    if (cr[N] && cv[N]) begin
      speed_r <= speed_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_speed_mm_s = speed_r;

  a_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_speed_mm_s >= tsp_pkg::FLOOR_SPEED)
    else $error("speed below floor");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (cv[0] && cv[N] && out_valid_r && out_stall))
    else $error("input stalled with an empty stage");

  a_root_done: assert property (@(posedge clk) disable iff (!rst_n)
    cv[N] |-> cd[N].bitw == '0)
    else $error("root chain left bits undecided");

  a_reset_empty: assert property (@(posedge clk)
    !$past(rst_n) |-> !out_valid_r)
    else $error("result valid right after reset");

endmodule
